// ===== rtl/dri_pkg.sv =====
// Shared constants and types for the dense id renaming table.
`timescale 1ns / 1ps
package dri_pkg;
	localparam int unsigned NUM_IDS_DEF = 1024;
	localparam int unsigned VID_W = 16;
	localparam int unsigned RID_W = 10;

	typedef enum logic {
		CMD_TO_LOCAL  = 1'b0,
		CMD_TO_GLOBAL = 1'b1
	} cmd_t;
endpackage

// ===== rtl/dri_fwd_map.sv =====
// Global-to-local store with assigned flag per entry and a clearing sweep after reset.
`timescale 1ns / 1ps
module dri_fwd_map #(
	parameter int unsigned NUM_IDS = dri_pkg::NUM_IDS_DEF,
	parameter int unsigned IDW = $clog2(NUM_IDS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  logic [IDW-1:0] rd_addr,
	output logic [IDW:0]   rd_data,
	input  logic           wr_en,
	input  logic [IDW-1:0] wr_addr,
	input  logic [IDW:0]   wr_data,
	output logic           clearing
);
	logic [IDW:0]   mem [NUM_IDS];
	logic [IDW-1:0] clr_idx_q;
	logic           clearing_q;
	logic           we;
	logic [IDW-1:0] wa;
	logic [IDW:0]   wd;

	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDW'(NUM_IDS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_comb begin
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_idx_q;
			wd = '0;
		end else begin
			we = wr_en;
			wa = wr_addr;
			wd = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/dri_rev_map.sv =====
// Local-to-global store, one write and one registered read port.
`timescale 1ns / 1ps
module dri_rev_map #(
	parameter int unsigned NUM_IDS = dri_pkg::NUM_IDS_DEF,
	parameter int unsigned IDW = $clog2(NUM_IDS)
) (
	input  logic           clk,
	input  logic           rd_en,
	input  logic [IDW-1:0] rd_addr,
	output logic [IDW-1:0] rd_data,
	input  logic           wr_en,
	input  logic [IDW-1:0] wr_addr,
	input  logic [IDW-1:0] wr_data
);
	logic [IDW-1:0] mem [NUM_IDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/dense_id_renaming_table.sv =====
// Top level of the dense id renaming table: command control, allocation and result register.
//
// For each item the two id stores are read first; then the entry is checked, a new local
// id is allocated and written back if needed, and the result is registered. done is high for
// one cycle, registered through vld_s1 and then done_q after start was taken, and busy is high
// from acceptance until that cycle, so the next item is taken then. After reset busy stays
// high while the assigned flags of all NUM_IDS entries are swept to zero. The receiver cannot
// stall: each result must be taken in the cycle that done marks.
`timescale 1ns / 1ps
module dense_id_renaming_table #(
	parameter int unsigned NUM_IDS = dri_pkg::NUM_IDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cmd,
	input  logic [dri_pkg::VID_W-1:0] vertex_id,
	output logic                      done,
	output logic [dri_pkg::RID_W-1:0] result_id,
	output logic                      newly_assigned,
	output logic                      out_of_range
);
	localparam int unsigned IDW = $clog2(NUM_IDS);
	localparam int unsigned WW = (IDW > dri_pkg::RID_W) ? IDW : dri_pkg::RID_W;

	logic           accept;
	logic           clearing;
	logic           oor_in;
	logic [IDW-1:0] idx_in;
	logic [IDW:0]   fwd_rd;
	logic [IDW-1:0] rev_rd;

	logic           vld_s1;
	dri_pkg::cmd_t  cmd_s1;
	logic [IDW-1:0] idx_s1;
	logic           oor_s1;

	logic [IDW:0]   next_q;
	logic           alloc;
	logic [IDW-1:0] res_id;
	logic           res_new;
	logic [WW-1:0]  res_wide;

	logic                      done_q;
	logic [dri_pkg::RID_W-1:0] result_id_q;
	logic                      newly_assigned_q;
	logic                      out_of_range_q;

	assign busy   = clearing | vld_s1;
	assign accept = start & ~busy;
	assign oor_in = {1'b0, vertex_id} >= (dri_pkg::VID_W + 1)'(NUM_IDS);
	assign idx_in = vertex_id[IDW-1:0];

	dri_fwd_map #(
		.NUM_IDS(NUM_IDS),
		.IDW(IDW)
	) u_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(idx_in),
		.rd_data(fwd_rd),
		.wr_en(alloc),
		.wr_addr(idx_s1),
		.wr_data({1'b1, next_q[IDW-1:0]}),
		.clearing(clearing)
	);

	dri_rev_map #(
		.NUM_IDS(NUM_IDS),
		.IDW(IDW)
	) u_rev (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(idx_in),
		.rd_data(rev_rd),
		.wr_en(alloc),
		.wr_addr(next_q[IDW-1:0]),
		.wr_data(idx_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dri_pkg::cmd_t'(cmd);
			idx_s1 <= idx_in;
			oor_s1 <= oor_in;
		end
	end

	always_comb begin
		alloc   = 1'b0;
		res_id  = '0;
		res_new = 1'b0;
		if (!oor_s1) begin
			unique case (cmd_s1)
				dri_pkg::CMD_TO_LOCAL: begin
					if (fwd_rd[IDW]) begin
						res_id = fwd_rd[IDW-1:0];
					end else if (next_q < (IDW + 1)'(NUM_IDS)) begin
						alloc   = vld_s1;
						res_id  = next_q[IDW-1:0];
						res_new = 1'b1;
					end
				end
				dri_pkg::CMD_TO_GLOBAL: begin
					if ({1'b0, idx_s1} < next_q) begin
						res_id = rev_rd;
					end
				end
				default: begin
					res_id = '0;
				end
			endcase
		end
		res_wide = WW'(res_id);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (alloc) begin
				next_q <= next_q + 1'b1;
			end
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_id_q      <= res_wide[dri_pkg::RID_W-1:0];
			newly_assigned_q <= res_new;
			out_of_range_q   <= oor_s1;
		end
	end

	assign done           = done_q;
	assign result_id      = result_id_q;
	assign newly_assigned = newly_assigned_q;
	assign out_of_range   = out_of_range_q;
endmodule

// ===== bench/dense_id_renaming_table_test.sv =====
// Self-checking testbench for the dense id renaming table: directed and random lookups.
`timescale 1ns / 1ps
module dense_id_renaming_table_test;
	localparam int unsigned ID_RANGE = dri_pkg::NUM_IDS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		dri_pkg::cmd_t             op;
		logic [dri_pkg::VID_W-1:0] vid;
		int unsigned               gap;
		bit                        drain;
	} id_cmd_t;

	typedef struct {
		logic [dri_pkg::RID_W-1:0] id;
		logic                      fresh;
		logic                      oor;
	} lookup_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      cmd = 1'b0;
	logic [dri_pkg::VID_W-1:0] vertex_id = '0;
	logic                      busy;
	logic                      done;
	logic [dri_pkg::RID_W-1:0] result_id;
	logic                      newly_assigned;
	logic                      out_of_range;

	id_cmd_t                   cmd_q[$];
	lookup_t                   lookup_q[$];
	logic [dri_pkg::RID_W-1:0] local_of[ID_RANGE];
	logic [dri_pkg::RID_W-1:0] global_of[ID_RANGE];
	bit                        claimed[ID_RANGE];
	int unsigned               next_free = 0;
	int unsigned               total_cmds = 0;
	int unsigned               cmds_issued = 0;
	int unsigned               lookups_seen = 0;
	int unsigned               mismatches = 0;
	int unsigned               n_fresh = 0;
	int unsigned               n_oor = 0;
	int unsigned               n_reverse = 0;
	int unsigned               burst_left = 0;
	int unsigned               cycles = 0;

	dense_id_renaming_table #(
		.NUM_IDS(ID_RANGE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.vertex_id(vertex_id),
		.done(done),
		.result_id(result_id),
		.newly_assigned(newly_assigned),
		.out_of_range(out_of_range)
	);

	function automatic lookup_t rename_id(dri_pkg::cmd_t op, logic [dri_pkg::VID_W-1:0] vid);
		lookup_t r;
		r.id = '0;
		r.fresh = 1'b0;
		r.oor = 1'b0;
		if (vid >= ID_RANGE) begin
			r.oor = 1'b1;
		end else if (op == dri_pkg::CMD_TO_LOCAL) begin
			if (claimed[vid]) begin
				r.id = local_of[vid];
			end else if (next_free < ID_RANGE) begin
				global_of[next_free] = vid[dri_pkg::RID_W-1:0];
				local_of[vid] = next_free[dri_pkg::RID_W-1:0];
				claimed[vid] = 1'b1;
				r.id = next_free[dri_pkg::RID_W-1:0];
				r.fresh = 1'b1;
				next_free++;
			end
		end else if (vid < next_free) begin
			r.id = global_of[vid];
		end
		return r;
	endfunction

	function automatic int unsigned pick_vid(int unsigned hi);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, hi);
	endfunction

	task automatic queue_cmd(dri_pkg::cmd_t op, int unsigned vid, bit drain);
		id_cmd_t c;
		if (burst_left > 0)
			burst_left--;
		else if ($urandom_range(0, 24) == 0)
			burst_left = $urandom_range(8, 40);
		c.op = op;
		c.vid = vid[dri_pkg::VID_W-1:0];
		c.gap = (burst_left > 0) ? 0 : $urandom_range(0, 17);
		c.drain = drain;
		cmd_q.push_back(c);
		total_cmds++;
	endtask

	task automatic check_field(string what, logic [dri_pkg::RID_W-1:0] exp,
		logic [dri_pkg::RID_W-1:0] got);
		if (got !== exp) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, exp, got);
			mismatches++;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, lookup_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : driver
		id_cmd_t     cur;
		bit          loaded;
		int unsigned idle_left;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= dri_pkg::CMD_TO_LOCAL;
			vertex_id <= '0;
			loaded = 1'b0;
			idle_left = 0;
		end else if (!start || !busy) begin
			if (start)
				cmds_issued++;
			if (!loaded && cmd_q.size() > 0) begin
				cur = cmd_q.pop_front();
				loaded = 1'b1;
				idle_left = cur.gap;
			end
			if (loaded && idle_left == 0 && (!cur.drain || lookups_seen == cmds_issued)) begin
				start <= 1'b1;
				cmd <= cur.op;
				vertex_id <= cur.vid;
				loaded = 1'b0;
			end else begin
				start <= 1'b0;
				cmd <= 1'($urandom_range(0, 1));
				vertex_id <= dri_pkg::VID_W'($urandom);
				if (loaded && idle_left > 0)
					idle_left--;
			end
		end
	end

	always @(posedge clk) begin : monitor
		lookup_t want;
		if (arst_n) begin
			if (done) begin
				if (lookup_q.size() == 0) begin
					$display("%0t: result with no item pending: id %0d new %b oor %b",
						$time, result_id, newly_assigned, out_of_range);
					mismatches++;
				end else begin
					want = lookup_q.pop_front();
					check_field("result_id", want.id, result_id);
					check_field("newly_assigned", dri_pkg::RID_W'(want.fresh),
						dri_pkg::RID_W'(newly_assigned));
					check_field("out_of_range", dri_pkg::RID_W'(want.oor),
						dri_pkg::RID_W'(out_of_range));
				end
				lookups_seen <= lookups_seen + 1;
			end
			if (start && !busy) begin
				want = rename_id(dri_pkg::cmd_t'(cmd), vertex_id);
				n_fresh += want.fresh;
				n_oor += want.oor;
				if (dri_pkg::cmd_t'(cmd) == dri_pkg::CMD_TO_GLOBAL)
					n_reverse++;
				lookup_q.push_back(want);
			end
		end
	end

	initial begin : stimulus
		int unsigned order[ID_RANGE];
		int unsigned j;
		int unsigned t;

		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 0, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 0, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 0, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, ID_RANGE - 1, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, ID_RANGE, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'hFFFF, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 16'hFFFF, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, ID_RANGE, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 0, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 1, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 2, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, ID_RANGE - 1, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'h02AA, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'h0155, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'h5555, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'hAAAA, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 16'h8000, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, ID_RANGE - 1, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 3, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 2, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'h0155, 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, 4, 1'b0);

		for (int i = 0; i < 560; i++) begin
			if ($urandom_range(0, 9) < 7)
				queue_cmd(dri_pkg::CMD_TO_LOCAL, pick_vid(ID_RANGE - 1),
					$urandom_range(0, 149) == 0);
			else
				queue_cmd(dri_pkg::CMD_TO_GLOBAL,
					pick_vid($urandom_range(0, 1) ? 255 : ID_RANGE - 1), 1'b0);
		end

		foreach (order[i])
			order[i] = i;
		for (int i = ID_RANGE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i]) begin
			queue_cmd(dri_pkg::CMD_TO_LOCAL, order[i], i == 0);
			if ($urandom_range(0, 7) == 0)
				queue_cmd(dri_pkg::CMD_TO_GLOBAL, $urandom_range(0, ID_RANGE - 1), 1'b0);
		end

		for (int i = 0; i < 200; i++)
			queue_cmd($urandom_range(0, 1) ? dri_pkg::CMD_TO_GLOBAL : dri_pkg::CMD_TO_LOCAL,
				pick_vid(ID_RANGE - 1), 1'b0);
		queue_cmd(dri_pkg::CMD_TO_GLOBAL, ID_RANGE - 1, 1'b1);
		queue_cmd(dri_pkg::CMD_TO_LOCAL, 16'hFFFF, 1'b0);

		wait (cmds_issued == total_cmds && lookups_seen == total_cmds);
		repeat (8) @(posedge clk);
		$display("%0d items: %0d new local ids, %0d reverse lookups, %0d ids out of range",
			total_cmds, n_fresh, n_reverse, n_oor);
		$display("table filled to %0d of %0d entries, %0d mismatches",
			next_free, ID_RANGE, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
